// ----- hdl/bmd_pkg.sv -----
// Shared types and constants for the banked memory map decoder.
`timescale 1ns / 1ps

package bmd_pkg;

  localparam logic [1:0] OP_READ       = 2'd0;
  localparam logic [1:0] OP_BUS_WRITE  = 2'd1;
  localparam logic [1:0] OP_LOAD_WRITE = 2'd2;

  localparam logic [1:0] CFG_FIXED_ROM    = 2'd0;
  localparam logic [1:0] CFG_SWITCHED_ROM = 2'd1;
  localparam logic [1:0] CFG_EXT_RAM      = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_ECHO   = 2'd1;
  localparam logic [1:0] STAT_GAP    = 2'd2;
  localparam logic [1:0] STAT_ROM_WR = 2'd3;

  localparam logic [15:0] ADDR_SW_ROM = 16'h4000;
  localparam logic [15:0] ADDR_VRAM   = 16'h8000;
  localparam logic [15:0] ADDR_ERAM   = 16'hA000;
  localparam logic [15:0] ADDR_WRAM   = 16'hC000;
  localparam logic [15:0] ADDR_ECHO   = 16'hE000;
  localparam logic [15:0] ADDR_OAM    = 16'hFE00;
  localparam logic [15:0] ADDR_GAP    = 16'hFEA0;
  localparam logic [15:0] ADDR_IO     = 16'hFF00;
  localparam logic [15:0] ADDR_HRAM   = 16'hFF80;
  localparam logic [15:0] ADDR_IE     = 16'hFFFF;

  localparam int ROM_OFF_W  = 14;
  localparam int RAM_OFF_W  = 13;
  localparam int VRAM_DEPTH = 8192;
  localparam int WRAM_DEPTH = 8192;
  localparam int OAM_DEPTH  = 160;
  localparam int IO_DEPTH   = 128;
  localparam int HRAM_DEPTH = 127;

  typedef enum logic [3:0] {
    RG_ROM0,
    RG_ROM1,
    RG_VRAM,
    RG_ERAM,
    RG_WRAM,
    RG_ECHO,
    RG_OAM,
    RG_GAP,
    RG_IO,
    RG_HRAM,
    RG_IE
  } region_t;

  typedef enum logic [0:0] {
    CS_CLEAR,
    CS_RUN
  } ctrl_state_t;

  typedef struct packed {
    logic clear;
    logic accept;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_stat_t;

endpackage

// ----- hdl/bmd_ctrl.sv -----
// Controller: clearing sweep after reset and the transfer handshake of both channels.
`timescale 1ns / 1ps

module bmd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output bmd_pkg::ctrl_cmd_t cmd,
  input  bmd_pkg::dp_stat_t  stat
);

  bmd_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmd_pkg::CS_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.clear  = 1'b0;
    cmd.accept = 1'b0;
    in_stall   = 1'b1;
    unique case (state_r)
      bmd_pkg::CS_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = bmd_pkg::CS_RUN;
        end
      end
      bmd_pkg::CS_RUN: begin
        in_stall   = out_valid_r && out_stall;
        cmd.accept = in_valid && !in_stall;
      end
      default: begin
        state_nxt = bmd_pkg::CS_CLEAR;
      end
    endcase
    if (cmd.accept) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> out_valid_r)
    else $error("accepted transfer produced no result");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled result was dropped");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bmd_pkg::CS_CLEAR) |-> (!out_valid_r && !cmd.accept))
    else $error("activity during clearing sweep");

  a_clear_ends_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.clear && stat.clear_last) |=> (state_r == bmd_pkg::CS_RUN))
    else $error("clearing sweep did not finish");

endmodule

// ----- hdl/bmd_datapath.sv -----
// Datapath: address decode, bank registers, memories and the result register.
`timescale 1ns / 1ps

module bmd_datapath #(
  parameter int ROM_BANKS = 8,
  parameter int RAM_BANKS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bmd_pkg::ctrl_cmd_t cmd,
  output bmd_pkg::dp_stat_t  stat,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [2:0]         cfg_wdata,
  input  logic [1:0]         in_op,
  input  logic [15:0]        in_bus_address,
  input  logic [7:0]         in_write_data,
  output logic [7:0]         out_read_data,
  output logic [1:0]         out_status
);

  localparam int ROM_DEPTH = ROM_BANKS * (1 << bmd_pkg::ROM_OFF_W);
  localparam int RAM_DEPTH = RAM_BANKS * (1 << bmd_pkg::RAM_OFF_W);
  localparam int ROM_BW    = (ROM_BANKS > 1) ? $clog2(ROM_BANKS) : 1;
  localparam int RAM_BW    = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
  localparam int ROM_AW    = $clog2(ROM_DEPTH);
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int CLR_DEPTH = (ROM_DEPTH > RAM_DEPTH) ? ROM_DEPTH : RAM_DEPTH;
  localparam int CLR_AW    = $clog2(CLR_DEPTH);

  // Bank numbers beyond the bank count wrap around by repeated subtraction.
  function automatic logic [ROM_BW-1:0] wrap_rom_bank(input logic [2:0] bank);
    logic [9:0] v;
    v = {7'd0, bank};
    for (int k = 0; k < 4; k++) begin
      if (v >= 10'(ROM_BANKS)) begin
        v = v - 10'(ROM_BANKS);
      end
    end
    return ROM_BW'(v);
  endfunction

  function automatic logic [RAM_BW-1:0] wrap_ram_bank(input logic [1:0] bank);
    logic [4:0] v;
    v = {3'd0, bank};
    for (int k = 0; k < 4; k++) begin
      if (v >= 5'(RAM_BANKS)) begin
        v = v - 5'(RAM_BANKS);
      end
    end
    return RAM_BW'(v);
  endfunction

  logic [2:0] fixed_bank_r;
  logic [2:0] switched_bank_r;
  logic [1:0] ext_bank_r;
  logic [7:0] ie_r;
  logic [CLR_AW-1:0] clr_cnt_r;

  logic [7:0] rom_mem  [ROM_DEPTH];
  logic [7:0] eram_mem [RAM_DEPTH];
  logic [7:0] vram_mem [bmd_pkg::VRAM_DEPTH];
  logic [7:0] wram_mem [bmd_pkg::WRAM_DEPTH];
  logic [7:0] oam_mem  [bmd_pkg::OAM_DEPTH];
  logic [7:0] io_mem   [bmd_pkg::IO_DEPTH];
  logic [7:0] hram_mem [bmd_pkg::HRAM_DEPTH];

  logic [7:0] rom_q_r, eram_q_r, vram_q_r, wram_q_r, oam_q_r, io_q_r, hram_q_r, ie_q_r;

  bmd_pkg::region_t region, region_r;
  logic             is_wr, is_wr_r;
  logic [1:0]       status, status_r;
  logic [2:0]       rom_bank;
  logic [ROM_BW-1:0] rom_bank_sel;
  logic [RAM_BW-1:0] ram_bank_sel;
  logic [ROM_AW-1:0] rom_addr, rom_wa;
  logic [RAM_AW-1:0] eram_addr, eram_wa;
  logic [12:0]       vram_wa, wram_wa;
  logic [7:0]        oam_wa;
  logic [6:0]        io_wa, hram_wa;
  logic              rom_we, eram_we, vram_we, wram_we, oam_we, io_we, hram_we;
  logic [7:0]        wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_bank_r    <= 3'd0;
      switched_bank_r <= 3'd1;
      ext_bank_r      <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        bmd_pkg::CFG_FIXED_ROM:    fixed_bank_r    <= cfg_wdata;
        bmd_pkg::CFG_SWITCHED_ROM: switched_bank_r <= cfg_wdata;
        bmd_pkg::CFG_EXT_RAM:      ext_bank_r      <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear && !stat.clear_last) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign stat.clear_last = (32'(clr_cnt_r) == CLR_DEPTH - 1);

  always_comb begin
    if (in_bus_address < bmd_pkg::ADDR_SW_ROM) begin
      region = bmd_pkg::RG_ROM0;
    end else if (in_bus_address < bmd_pkg::ADDR_VRAM) begin
      region = bmd_pkg::RG_ROM1;
    end else if (in_bus_address < bmd_pkg::ADDR_ERAM) begin
      region = bmd_pkg::RG_VRAM;
    end else if (in_bus_address < bmd_pkg::ADDR_WRAM) begin
      region = bmd_pkg::RG_ERAM;
    end else if (in_bus_address < bmd_pkg::ADDR_ECHO) begin
      region = bmd_pkg::RG_WRAM;
    end else if (in_bus_address < bmd_pkg::ADDR_OAM) begin
      region = bmd_pkg::RG_ECHO;
    end else if (in_bus_address < bmd_pkg::ADDR_GAP) begin
      region = bmd_pkg::RG_OAM;
    end else if (in_bus_address < bmd_pkg::ADDR_IO) begin
      region = bmd_pkg::RG_GAP;
    end else if (in_bus_address < bmd_pkg::ADDR_HRAM) begin
      region = bmd_pkg::RG_IO;
    end else if (in_bus_address < bmd_pkg::ADDR_IE) begin
      region = bmd_pkg::RG_HRAM;
    end else begin
      region = bmd_pkg::RG_IE;
    end
  end

  assign is_wr = (in_op == bmd_pkg::OP_BUS_WRITE) || (in_op == bmd_pkg::OP_LOAD_WRITE);

  always_comb begin
    unique case (region) inside
      bmd_pkg::RG_ROM0, bmd_pkg::RG_ROM1: begin
        status = (in_op == bmd_pkg::OP_BUS_WRITE) ? bmd_pkg::STAT_ROM_WR : bmd_pkg::STAT_OK;
      end
      bmd_pkg::RG_ECHO: status = bmd_pkg::STAT_ECHO;
      bmd_pkg::RG_GAP:  status = bmd_pkg::STAT_GAP;
      default:          status = bmd_pkg::STAT_OK;
    endcase
  end

  assign rom_bank     = (region == bmd_pkg::RG_ROM0) ? fixed_bank_r : switched_bank_r;
  assign rom_bank_sel = wrap_rom_bank(rom_bank);
  assign ram_bank_sel = wrap_ram_bank(ext_bank_r);
  assign rom_addr     = ROM_AW'({rom_bank_sel, in_bus_address[bmd_pkg::ROM_OFF_W-1:0]});
  assign eram_addr    = RAM_AW'({ram_bank_sel, in_bus_address[bmd_pkg::RAM_OFF_W-1:0]});

  always_comb begin
    wdata   = cmd.clear ? 8'd0 : in_write_data;
    rom_wa  = cmd.clear ? clr_cnt_r[ROM_AW-1:0] : rom_addr;
    eram_wa = cmd.clear ? clr_cnt_r[RAM_AW-1:0] : eram_addr;
    vram_wa = cmd.clear ? clr_cnt_r[12:0] : in_bus_address[12:0];
    wram_wa = cmd.clear ? clr_cnt_r[12:0] : in_bus_address[12:0];
    oam_wa  = cmd.clear ? clr_cnt_r[7:0] : in_bus_address[7:0];
    io_wa   = cmd.clear ? clr_cnt_r[6:0] : in_bus_address[6:0];
    hram_wa = cmd.clear ? clr_cnt_r[6:0] : in_bus_address[6:0];
    if (cmd.clear) begin
      rom_we  = 32'(clr_cnt_r) < ROM_DEPTH;
      eram_we = 32'(clr_cnt_r) < RAM_DEPTH;
      vram_we = 32'(clr_cnt_r) < bmd_pkg::VRAM_DEPTH;
      wram_we = 32'(clr_cnt_r) < bmd_pkg::WRAM_DEPTH;
      oam_we  = 32'(clr_cnt_r) < bmd_pkg::OAM_DEPTH;
      io_we   = 32'(clr_cnt_r) < bmd_pkg::IO_DEPTH;
      hram_we = 32'(clr_cnt_r) < bmd_pkg::HRAM_DEPTH;
    end else begin
      rom_we  = cmd.accept && (in_op == bmd_pkg::OP_LOAD_WRITE) &&
                ((region == bmd_pkg::RG_ROM0) || (region == bmd_pkg::RG_ROM1));
      eram_we = cmd.accept && is_wr && (region == bmd_pkg::RG_ERAM);
      vram_we = cmd.accept && is_wr && (region == bmd_pkg::RG_VRAM);
      wram_we = cmd.accept && is_wr &&
                ((region == bmd_pkg::RG_WRAM) || (region == bmd_pkg::RG_ECHO));
      oam_we  = cmd.accept && is_wr && (region == bmd_pkg::RG_OAM);
      io_we   = cmd.accept && is_wr && (region == bmd_pkg::RG_IO);
      hram_we = cmd.accept && is_wr && (region == bmd_pkg::RG_HRAM);
    end
  end

  always_ff @(posedge clk) begin
    if (rom_we) rom_mem[rom_wa] <= wdata;
    if (cmd.accept) rom_q_r <= rom_mem[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (eram_we) eram_mem[eram_wa] <= wdata;
    if (cmd.accept) eram_q_r <= eram_mem[eram_addr];
  end

  always_ff @(posedge clk) begin
    if (vram_we) vram_mem[vram_wa] <= wdata;
    if (cmd.accept) vram_q_r <= vram_mem[in_bus_address[12:0]];
  end

  always_ff @(posedge clk) begin
    if (wram_we) wram_mem[wram_wa] <= wdata;
    if (cmd.accept) wram_q_r <= wram_mem[in_bus_address[12:0]];
  end

  always_ff @(posedge clk) begin
    if (oam_we) oam_mem[oam_wa] <= wdata;
    if (cmd.accept && (region == bmd_pkg::RG_OAM)) oam_q_r <= oam_mem[in_bus_address[7:0]];
  end

  always_ff @(posedge clk) begin
    if (io_we) io_mem[io_wa] <= wdata;
    if (cmd.accept) io_q_r <= io_mem[in_bus_address[6:0]];
  end

  always_ff @(posedge clk) begin
    if (hram_we) hram_mem[hram_wa] <= wdata;
    if (cmd.accept && (region == bmd_pkg::RG_HRAM)) begin
      hram_q_r <= hram_mem[in_bus_address[6:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ie_r <= 8'd0;
    end else if (cmd.accept && is_wr && (region == bmd_pkg::RG_IE)) begin
      ie_r <= in_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ie_q_r   <= ie_r;
      region_r <= region;
      is_wr_r  <= is_wr;
      status_r <= status;
    end
  end

  always_comb begin
    out_read_data = 8'd0;
    if (!is_wr_r) begin
      case (region_r) inside
        bmd_pkg::RG_ROM0, bmd_pkg::RG_ROM1: out_read_data = rom_q_r;
        bmd_pkg::RG_VRAM:                   out_read_data = vram_q_r;
        bmd_pkg::RG_ERAM:                   out_read_data = eram_q_r;
        bmd_pkg::RG_WRAM, bmd_pkg::RG_ECHO: out_read_data = wram_q_r;
        bmd_pkg::RG_OAM:                    out_read_data = oam_q_r;
        bmd_pkg::RG_IO:                     out_read_data = io_q_r;
        bmd_pkg::RG_HRAM:                   out_read_data = hram_q_r;
        bmd_pkg::RG_IE:                     out_read_data = ie_q_r;
        default:                            out_read_data = 8'd0;
      endcase
    end
  end

  assign out_status = status_r;

endmodule

// ----- hdl/banked_memory_map_decoder.sv -----
// Top level of the banked memory map decoder: controller and datapath.
//
//   Channel  Ports                                         Direction
//   in       in_valid, in_stall, in_op, in_bus_address,    access in
//            in_write_data
//   out      out_valid, out_stall, out_read_data,          result out
//            out_status
//   cfg      cfg_we, cfg_index, cfg_wdata                  bank registers in
//
// One transfer per cycle is taken while no result is stalled and the sweep is over;
// its result appears in the next cycle, from the registered memory read ports.
// After reset every memory is swept to zero, one entry a cycle, by a counter that
// spans the larger of the ROM and ext RAM depths; no input transfer is taken then.
// While a result is stalled the input is stalled too and the result holds.
`timescale 1ns / 1ps

module banked_memory_map_decoder #(
  parameter int ROM_BANKS = 8,
  parameter int RAM_BANKS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_bus_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_wdata
);

  bmd_pkg::ctrl_cmd_t cmd;
  bmd_pkg::dp_stat_t  stat;

  bmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  bmd_datapath #(
    .ROM_BANKS (ROM_BANKS),
    .RAM_BANKS (RAM_BANKS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_op          (in_op),
    .in_bus_address (in_bus_address),
    .in_write_data  (in_write_data),
    .out_read_data  (out_read_data),
    .out_status     (out_status)
  );

endmodule
